FILE: design/bero_pkg.sv
package bero_pkg;

  // Default frame limits and the size that reset loads into both registers.
  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;
  localparam int RESET_SIZE         = 1024;

  // Fixed widths of the configuration port and of the stream payloads.
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam int COORD_BITS     = 10;
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 24;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - 2 * COORD_BITS - 1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Two line-delay bits carried by one chain cell: newer is one row back,
  // older is two rows back.
  typedef struct packed {
    logic older;
    logic newer;
  } pair_t;

  // Which sides of the window lie inside the frame.
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } edge_mask_t;

  // One result transaction.
  typedef struct packed {
    logic                  last;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  eroded;
  } result_t;

endpackage

FILE: design/bero_cell.sv
module bero_cell (
  input  logic               clk,
  input  logic               shift_en,
  input  logic               entry,
  input  bero_pkg::pair_t    entry_data,
  input  bero_pkg::pair_t    prev_data,
  output bero_pkg::pair_t    data_q
);

  bero_pkg::pair_t data_r;
  bero_pkg::pair_t data_nxt;

  // On a shift, the entry cell loads the new bits, every other cell takes its neighbor's.
  always_comb begin
    data_nxt = data_r;
    if (shift_en) begin
      data_nxt = entry ? entry_data : prev_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

FILE: design/bero_chain.sv
module bero_chain #(
  parameter int MAX_WIDTH = bero_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             shift_en,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   width,
  input  logic                             pixel,
  output bero_pkg::pair_t                  tail
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  bero_pkg::pair_t cell_q [MAX_WIDTH];
  bero_pkg::pair_t entry_data;

  // New pixel enters the one-row delay; the one-row tail enters the second.
  assign entry_data.newer = pixel;
  assign entry_data.older = cell_q[MAX_WIDTH-1].newer;

  // Data enters at cell MAX_WIDTH - width, so it leaves the last cell after
  // exactly width shifts.
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    bero_pkg::pair_t prev_data;
    logic            entry;

    if (i == 0) begin : g_head
      assign prev_data = '1;
    end else begin : g_body
      assign prev_data = cell_q[i-1];
    end

    assign entry = (width == WW'(MAX_WIDTH - i));

    bero_cell u_cell (
      .clk        (clk),
      .shift_en   (shift_en),
      .entry      (entry),
      .entry_data (entry_data),
      .prev_data  (prev_data),
      .data_q     (cell_q[i])
    );
  end

  assign tail = cell_q[MAX_WIDTH-1];

endmodule

FILE: design/bero_window.sv
module bero_window (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic                   pixel,
  input  bero_pkg::pair_t        tail,
  input  bero_pkg::edge_mask_t   mask,
  output logic                   eroded
);

  // Two older columns of the 3x3 window; the newest column comes from the
  // current pixel and the line-delay tails.
  logic bot1_r, bot2_r, mid1_r, mid2_r, top1_r, top2_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      bot1_r <= pixel;
      bot2_r <= bot1_r;
      mid1_r <= tail.newer;
      mid2_r <= mid1_r;
      top1_r <= tail.older;
      top2_r <= top1_r;
    end
  end

  // Neighbors outside the frame count as set.
  always_comb begin
    logic t_out, b_out, l_out, r_out;
    t_out  = !mask.top_ok;
    b_out  = !mask.bot_ok;
    l_out  = !mask.left_ok;
    r_out  = !mask.right_ok;
    eroded = mid1_r
           & (top1_r | t_out) & (bot1_r | b_out)
           & (mid2_r | l_out) & (tail.newer | r_out)
           & (top2_r | t_out | l_out) & (tail.older | t_out | r_out)
           & (bot2_r | b_out | l_out) & (pixel | b_out | r_out);
  end

endmodule

FILE: design/binary_erosion_3x3.sv
// Each result is registered onto out_tvalid from the transaction that completes
// its 3x3 neighborhood (one row plus one pixel later in the stream).
// Throughput: one input transaction per cycle while in_tready is high, set by the
// line-delay cell chain that shifts once per pixel. Single-row frames and 2x1
// frames hold input at frame end while the window catches up.
// Reset (rst_n low, synchronous): counters cleared, sizes 1024 or the limit if less.
module binary_erosion_3x3 #(
  parameter int MAX_WIDTH  = bero_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = bero_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [bero_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bero_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bero_pkg::IN_TDATA_BITS-1:0]  in_tdata,  // [0] pixel_in
  input  logic                                in_tuser,  // [0] drain
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bero_pkg::OUT_TDATA_BITS-1:0] out_tdata, // [0] eroded_pixel,
                                                         // [10:1] out_row,
                                                         // [20:11] out_col
  output logic                                out_tlast  // frame_last
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int LW = $clog2(MAX_WIDTH + 2);
  localparam int RESET_W = (bero_pkg::RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH
                                                               : bero_pkg::RESET_SIZE;
  localparam int RESET_H = (bero_pkg::RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : bero_pkg::RESET_SIZE;

  logic [WW-1:0] w_r, w_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [CW-1:0] pcol_r, pcol_nxt;
  logic [HW-1:0] prow_r, prow_nxt;
  logic [CW-1:0] rcol_r, rcol_nxt;
  logic [RW-1:0] rrow_r, rrow_nxt;
  logic [LW-1:0] lead_r, lead_nxt;
  logic          catchup_r, catchup_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  bero_pkg::result_t out_data_r, out_data_nxt;
  bero_pkg::result_t skid_data_r, skid_data_nxt;

  logic [31:0]          cfg_val;
  logic [WW-1:0]        w_cfg;
  logic [HW-1:0]        h_cfg;
  logic [WW-1:0]        w_m1;
  logic [HW-1:0]        h_m1;
  logic                 in_acc;
  logic                 done;
  logic                 real_push;
  logic                 push;
  logic                 lead_full;
  logic                 emit;
  logic                 res_last;
  logic                 frame_fill;
  logic                 win_pixel;
  logic                 eroded;
  bero_pkg::pair_t      tail;
  bero_pkg::edge_mask_t mask;
  bero_pkg::result_t    res;

  // Register values: zero acts as one, anything above the limit as the limit.
  assign cfg_val = 32'(cfg_wdata);
  assign w_cfg   = (cfg_val == 32'd0) ? WW'(1) :
                   (cfg_val > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_val);
  assign h_cfg   = (cfg_val == 32'd0) ? HW'(1) :
                   (cfg_val > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_val);

  assign w_m1 = w_r - WW'(1);
  assign h_m1 = h_r - HW'(1);

  // Input is held while the skid stage is full or the window catches up.
  assign in_tready = !skid_valid_r && !catchup_r;
  assign in_acc    = in_tvalid && in_tready;
  assign done      = (prow_r == h_r);

  // A push advances the window: a real pixel, or a filler once the frame is in.
  assign real_push  = in_acc && !in_tuser && !done;
  assign push       = real_push || (in_acc && done) || (catchup_r && !skid_valid_r);
  assign lead_full  = (lead_r == LW'(w_r) + LW'(1));
  assign emit       = push && lead_full;
  assign res_last   = (HW'(rrow_r) == h_m1) && (WW'(rcol_r) == w_m1);
  assign frame_fill = real_push && (WW'(pcol_r) == w_m1) && (prow_r == h_m1);
  assign win_pixel  = real_push ? in_tdata[0] : 1'b1;

  // Frame edges seen from the result pixel.
  assign mask.top_ok   = (rrow_r != '0);
  assign mask.bot_ok   = (HW'(rrow_r) != h_m1);
  assign mask.left_ok  = (rcol_r != '0);
  assign mask.right_ok = (WW'(rcol_r) != w_m1);

  bero_chain #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_chain (
    .clk      (clk),
    .shift_en (push),
    .width    (w_r),
    .pixel    (win_pixel),
    .tail     (tail)
  );

  bero_window u_window (
    .clk      (clk),
    .shift_en (push),
    .pixel    (win_pixel),
    .tail     (tail),
    .mask     (mask),
    .eroded   (eroded)
  );

  assign res.eroded = eroded;
  assign res.row    = bero_pkg::COORD_BITS'(rrow_r);
  assign res.col    = bero_pkg::COORD_BITS'(rcol_r);
  assign res.last   = res_last;

  // Size registers, frame position counters and the catch-up flag.
  always_comb begin
    w_nxt       = w_r;
    h_nxt       = h_r;
    pcol_nxt    = pcol_r;
    prow_nxt    = prow_r;
    rcol_nxt    = rcol_r;
    rrow_nxt    = rrow_r;
    lead_nxt    = lead_r;
    catchup_nxt = catchup_r;
    if (cfg_we) begin
      unique case (bero_pkg::cfg_reg_t'(cfg_index))
        bero_pkg::REG_IMAGE_WIDTH:  w_nxt = w_cfg;
        bero_pkg::REG_IMAGE_HEIGHT: h_nxt = h_cfg;
      endcase
      pcol_nxt    = '0;
      prow_nxt    = '0;
      rcol_nxt    = '0;
      rrow_nxt    = '0;
      lead_nxt    = '0;
      catchup_nxt = 1'b0;
    end else begin
      if (real_push) begin
        if (WW'(pcol_r) == w_m1) begin
          pcol_nxt = '0;
          prow_nxt = prow_r + HW'(1);
        end else begin
          pcol_nxt = pcol_r + CW'(1);
        end
      end
      if (push && !lead_full) begin
        lead_nxt = lead_r + LW'(1);
      end
      if (frame_fill && !emit) begin
        catchup_nxt = 1'b1;
      end
      if (emit) begin
        catchup_nxt = 1'b0;
        if (res_last) begin
          pcol_nxt = '0;
          prow_nxt = '0;
          rcol_nxt = '0;
          rrow_nxt = '0;
          lead_nxt = '0;
        end else if (WW'(rcol_r) == w_m1) begin
          rcol_nxt = '0;
          rrow_nxt = rrow_r + RW'(1);
        end else begin
          rcol_nxt = rcol_r + CW'(1);
        end
      end
    end
  end

  // Output register with a skid stage behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = emit;
        out_data_nxt  = res;
      end
    end else if (emit) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r          <= WW'(RESET_W);
      h_r          <= HW'(RESET_H);
      pcol_r       <= '0;
      prow_r       <= '0;
      rcol_r       <= '0;
      rrow_r       <= '0;
      lead_r       <= '0;
      catchup_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      w_r          <= w_nxt;
      h_r          <= h_nxt;
      pcol_r       <= pcol_nxt;
      prow_r       <= prow_nxt;
      rcol_r       <= rcol_nxt;
      rrow_r       <= rrow_nxt;
      lead_r       <= lead_nxt;
      catchup_r    <= catchup_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_data_r.last;
  assign out_tdata  = {{bero_pkg::OUT_PAD_BITS{1'b0}}, out_data_r.col,
                       out_data_r.row, out_data_r.eroded};

  // The skid stage only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  // Catch-up happens only once the whole frame is in.
  a_catchup_done: assert property (@(posedge clk) disable iff (!rst_n)
    catchup_r |-> (prow_r == h_r))
    else $error("window catch-up outside the end of a frame");

  // The window never runs more than one row plus one pixel ahead of results.
  a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r <= LW'(w_r) + LW'(1))
    else $error("window lead exceeds one row plus one pixel");

  // The final result of a frame returns all counters to the frame start.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res_last) |=> (prow_r == '0 && pcol_r == '0 && rrow_r == '0 &&
                            rcol_r == '0 && lead_r == '0))
    else $error("counters not cleared after the last result of a frame");

endmodule
